// ===== rtl/core/ptm_pkg.sv =====
// Shared types and constants for the predecessor-take multiset.
// No dependencies; imported by every module of the block.
package ptm_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned VALUE_W      = 32;
  // Command queue depth between front and back; must be a power of two.
  localparam int unsigned QDEPTH       = 2;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_TAKE   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  // One classified command word handed from front to back.
  typedef struct packed {
    cmd_e               kind;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

// ===== rtl/core/predecessor_take_multiset.sv =====
// Top level of the predecessor-take multiset; depends on ptm_pkg, ptm_front, ptm_back.
// An insert result passes the command queue and the result register; a take scans
// the store (S_SCAN, S_DONE) first, unless the store is empty.
// Throughput: one insert per cycle while the result side does not stall; a take holds the back end
// for its scan, set by the single read port of the value memory (one value compared per cycle).
// Reset (async, active low) empties the store and queue; no clearing pass.
module predecessor_take_multiset #(
  parameter int unsigned CAPACITY = ptm_pkg::CAPACITY_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ptm_pkg::VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
  input  logic                         s_axis_tuser,   // [0] command
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ptm_pkg::VALUE_W-1:0]  m_axis_tdata,   // [31:0] taken_value
  output logic [1:0]                   m_axis_tuser    // [1:0] status
);
  import ptm_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // accept and queue
  ptm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  // execute against the store
  ptm_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== rtl/core/ptm_front.sv =====
// Front end: accepts input words, classifies them and queues them.
// Depends on ptm_pkg.
module ptm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ptm_pkg::VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
  input  logic                         s_axis_tuser,   // [0] command
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output ptm_pkg::cmd_t                cmd_o
);
  import ptm_pkg::*;

  localparam int unsigned QPtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCntW = $clog2(QDEPTH + 1);

  cmd_t             queue_q [QDEPTH];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;
  cmd_t             in_cmd;

  // classify the incoming word
  always_comb begin
    in_cmd.kind  = cmd_e'(s_axis_tuser);
    in_cmd.value = s_axis_tdata;
  end

  assign s_axis_tready = (cnt_q != QCntW'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != '0);
  assign pop           = cmd_valid_o && cmd_ready_i;
  assign cmd_o         = queue_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

// ===== rtl/core/ptm_back.sv =====
// Back end: executes insert and take commands on a compact value memory
// and holds the result word. Depends on ptm_pkg.
module ptm_back #(
  parameter int unsigned CAPACITY = ptm_pkg::CAPACITY_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  ptm_pkg::cmd_t                cmd_i,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ptm_pkg::VALUE_W-1:0]  m_axis_tdata,   // [31:0] taken_value
  output logic [1:0]                   m_axis_tuser    // [1:0] status
);
  import ptm_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // Values live packed in slots 0 .. count-1; removal moves the last one in.
  logic [VALUE_W-1:0] mem [CAPACITY];

  state_e             state_q;
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    issue_q;
  logic               cmp_v_q;
  logic [IdxW-1:0]    cmp_idx_q;
  logic [VALUE_W-1:0] rd_data_q;
  logic [VALUE_W-1:0] limit_q;
  logic               have_q;
  logic [VALUE_W-1:0] best_q;
  logic [IdxW-1:0]    best_idx_q;
  logic [VALUE_W-1:0] last_q;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q;
  logic [VALUE_W-1:0] out_value_q;

  logic               out_free;
  logic               pop;
  logic               issue;
  logic [IdxW-1:0]    rd_addr;
  logic [IdxW-1:0]    last_idx;
  logic               hit;
  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // scan address issue and compare stage
  assign issue    = (state_q == S_SCAN) && (issue_q < count_q);
  assign rd_addr  = issue_q[IdxW-1:0];
  assign last_idx = IdxW'(count_q - CntW'(1));
  assign hit      = (rd_data_q <= limit_q) && (!have_q || (rd_data_q > best_q));

  // single write port: insert at the tail, or fill the hole on removal
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IdxW-1:0];
    mem_wdata = cmd_i.value;
    if (pop && (cmd_i.kind == CMD_INSERT) && (count_q != CntW'(CAPACITY))) begin
      mem_we = 1'b1;
    end else if ((state_q == S_DONE) && have_q) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx_q;
      mem_wdata = last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  // result valid: held while stalled, set by an immediate or a finished command
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (pop && ((cmd_i.kind == CMD_INSERT) || (count_q == '0))) begin
      out_valid_d = 1'b1;
    end else if (state_q == S_DONE) begin
      out_valid_d = 1'b1;
    end
  end

  // command sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      issue_q      <= '0;
      cmp_v_q      <= 1'b0;
      cmp_idx_q    <= '0;
      limit_q      <= '0;
      have_q       <= 1'b0;
      best_q       <= '0;
      best_idx_q   <= '0;
      last_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_INSERTED;
      out_value_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (pop) begin
            if (cmd_i.kind == CMD_INSERT) begin
              out_value_q <= '0;
              if (count_q == CntW'(CAPACITY)) begin
                out_status_q <= ST_FULL;
              end else begin
                out_status_q <= ST_INSERTED;
                count_q      <= count_q + CntW'(1);
              end
            end else if (count_q == '0) begin
              out_status_q <= ST_NONE;
              out_value_q  <= '0;
            end else begin
              limit_q <= cmd_i.value;
              issue_q <= '0;
              cmp_v_q <= 1'b0;
              have_q  <= 1'b0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_v_q   <= issue;
          cmp_idx_q <= rd_addr;
          if (issue) begin
            issue_q <= issue_q + CntW'(1);
          end
          if (cmp_v_q) begin
            if (hit) begin
              have_q     <= 1'b1;
              best_q     <= rd_data_q;
              best_idx_q <= cmp_idx_q;
            end
            if (cmp_idx_q == last_idx) begin
              last_q  <= rd_data_q;
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // result register is known free: it was free when the take was popped
          if (have_q) begin
            out_status_q <= ST_FOUND;
            out_value_q  <= best_q;
            count_q      <= count_q - CntW'(1);
          end else begin
            out_status_q <= ST_NONE;
            out_value_q  <= '0;
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

endmodule

// ===== rtl/core/ptm_checker.sv =====
// Port-level checks for predecessor_take_multiset, bound to the top level.
// Depends on ptm_pkg.
module ptm_props (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [ptm_pkg::VALUE_W-1:0]  s_axis_tdata,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [ptm_pkg::VALUE_W-1:0]  m_axis_tdata,
  input logic [1:0]                   m_axis_tuser
);
  import ptm_pkg::*;

  logic       in_acc, out_acc;
  logic [3:0] pending_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // words accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  // a waiting input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input word changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // only a removal carries a value
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_FOUND) |-> (m_axis_tdata == '0))
    else $error("nonzero value without a removal");

  // no result without an earlier accepted word
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pending_q != '0))
    else $error("result without a pending word");

  // reset leaves the result side empty
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind predecessor_take_multiset ptm_props u_ptm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/ptm_checker.sv =====
`timescale 1ns / 1ps
// Checker for the predecessor-take multiset: watches both stream channels,
// keeps its own copy of the store and compares every result word in order.
// Depends on ptm_pkg for the command and status codes.
module ptm_checker #(
  parameter int unsigned CAPACITY = ptm_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [ptm_pkg::VALUE_W-1:0] s_tdata_i,   // [31:0] value
  input  logic                        s_tuser_i,   // [0] command
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [ptm_pkg::VALUE_W-1:0] m_tdata_i,   // [31:0] taken_value
  input  logic [1:0]                  m_tuser_i,   // [1:0] status
  output int unsigned                 fail_cnt_o,
  output int unsigned                 pending_o
);
  import ptm_pkg::*;

  localparam int NO_SLOT = -1;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] taken;
  } outcome_t;

  // Shadow store
  logic [VALUE_W-1:0] slot_val  [CAPACITY];
  logic               slot_used [CAPACITY];
  int unsigned        used_cnt;
  outcome_t           outcome_q [$];
  int unsigned        fail_cnt = 0;

  assign fail_cnt_o = fail_cnt;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_cnt++;
  endtask

  // Apply one command word to the shadow store and return its outcome.
  // Insert fills the lowest free slot; take removes the largest value <= limit.
  function automatic outcome_t apply_word(cmd_e kind, logic [VALUE_W-1:0] val);
    outcome_t res;
    int       best_slot;
    res.status = ST_NONE;
    res.taken  = '0;
    best_slot  = NO_SLOT;
    if (kind == CMD_INSERT) begin
      res.status = ST_FULL;
      if (used_cnt < CAPACITY) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (!slot_used[i] && res.status == ST_FULL) begin
            slot_val[i]  = val;
            slot_used[i] = 1'b1;
            used_cnt++;
            res.status   = ST_INSERTED;
          end
        end
      end
    end else begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot_used[i] && slot_val[i] <= val &&
            (best_slot == NO_SLOT || slot_val[i] > res.taken)) begin
          best_slot = i;
          res.taken = slot_val[i];
        end
      end
      if (best_slot != NO_SLOT) begin
        slot_used[best_slot] = 1'b0;
        used_cnt--;
        res.status = ST_FOUND;
      end
    end
    return res;
  endfunction

  // Predict on accepted input words, compare on accepted result words
  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
      used_cnt = 0;
      outcome_q.delete();
      pending_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        outcome_q.insert(outcome_q.size(), apply_word(cmd_e'(s_tuser_i), s_tdata_i));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result word: status %0d value %h",
                                    m_tuser_i, m_tdata_i));
        end else begin
          want = outcome_q.pop_front();
          if (m_tuser_i !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %s",
                                      m_tuser_i, want.status.name()));
          end
          if (m_tdata_i !== want.taken) begin
            report_mismatch($sformatf("taken_value %h, expected %h",
                                      m_tdata_i, want.taken));
          end
        end
      end
      pending_o <= outcome_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the predecessor-take multiset testbench: clock, reset, stimulus
// with random gaps and stalls, and the verdict. Depends on ptm_pkg,
// the block itself and ptm_checker.
module tb_top;
  import ptm_pkg::*;

  localparam int unsigned RAND_WORDS   = 700;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // Longest take scans the whole store, plus its overhead
  localparam int unsigned DRAIN_CYCLES = CAPACITY_DEF + 40;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [VALUE_W-1:0] s_tdata  = '0;
  cmd_e               s_tuser  = CMD_INSERT;
  logic               m_axis_tvalid;
  logic               m_tready = 1'b0;
  logic [VALUE_W-1:0] m_axis_tdata;
  logic [1:0]         m_axis_tuser;
  int unsigned        fail_cnt;
  int unsigned        pending;
  int unsigned        cycle_cnt = 0;
  bit                 src_burst = 1'b0;
  bit                 snk_burst = 1'b0;

  always #1 clk_i = ~clk_i;

  predecessor_take_multiset i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  ptm_checker #(
    .CAPACITY (CAPACITY_DEF)
  ) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // Values: many small ones for duplicates and hits, some extremes, rest random
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 30) return $urandom_range(15, 0);
    if (sel < 40) begin
      case ($urandom_range(3, 0))
        0:       return '0;
        1:       return '1;
        2:       return 32'hFFFF_FFFE;
        default: return 32'd1;
      endcase
    end
    return $urandom();
  endfunction

  // Limits: full range often, so that takes drain the store
  function automatic logic [VALUE_W-1:0] pick_limit();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 25) return '1;
    if (sel < 50) return $urandom_range(15, 0);
    if (sel < 60) return '0;
    return $urandom();
  endfunction

  // Send one word after a random gap; returns once s_axis_tready is seen high after an edge
  task automatic send_word(input cmd_e kind, input logic [VALUE_W-1:0] val);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(17, 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= val;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if ($urandom_range(39, 0) == 0) src_burst = !src_burst;
  endtask

  // Result side: random stall before each word, with stretches of none
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = snk_burst ? 0 : $urandom_range(17, 0);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      if ($urandom_range(39, 0) == 0) snk_burst = !snk_burst;
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int unsigned ins_pct;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty store: nothing found, even at the extremes of the limit
    send_word(CMD_TAKE, '0);
    send_word(CMD_TAKE, '1);
    // Extremes and equal copies
    send_word(CMD_INSERT, '0);
    send_word(CMD_INSERT, '1);
    send_word(CMD_INSERT, 32'd5);
    send_word(CMD_INSERT, 32'd5);
    send_word(CMD_INSERT, 32'd7);
    send_word(CMD_INSERT, 32'd100);
    send_word(CMD_TAKE, 32'd4);
    send_word(CMD_TAKE, 32'd6);
    send_word(CMD_TAKE, 32'd6);
    send_word(CMD_TAKE, 32'd6);
    send_word(CMD_TAKE, 32'hFFFF_FFFE);
    send_word(CMD_TAKE, '1);
    send_word(CMD_TAKE, '1);
    send_word(CMD_TAKE, '1);
    // Slot reuse after removal
    send_word(CMD_INSERT, 32'd9);
    send_word(CMD_TAKE, 32'd9);

    // Random phases: mixed, fill past full, drain, mixed
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n < 150)      ins_pct = 60;
      else if (n < 430) ins_pct = 95;
      else if (n < 630) ins_pct = 15;
      else              ins_pct = 50;
      if ($urandom_range(99, 0) < ins_pct) send_word(CMD_INSERT, pick_value());
      else                                 send_word(CMD_TAKE, pick_limit());
    end
    s_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/core/ptm_pkg.sv
rtl/core/ptm_front.sv
rtl/core/ptm_back.sv
rtl/core/predecessor_take_multiset.sv
rtl/core/ptm_checker.sv
verif/ptm_checker.sv
verif/tb_top.sv
